/* hw/rtl/ufn_pkg.sv */
// ----------------------------------------------------------------------------
// ufn_pkg
// Shared types, constants and the fold table of the accent-folding normalizer.
// ----------------------------------------------------------------------------
package ufn_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] LEAD_BYTE  = 8'hC3;
  localparam logic [BYTE_W-1:0] BYTE_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] BYTE_HYPHEN = 8'h2D;
  localparam logic [BYTE_W-1:0] BYTE_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] BYTE_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              last;
  } ufn_res_t;

  typedef struct packed {
    logic lead_pending;
    logic text_started;
    logic space_held;
  } ufn_state_t;

  function automatic logic [CHAR_W-1:0] fold_second(input logic [BYTE_W-1:0] b);
    logic [CHAR_W-1:0] r;
    r = CHAR_NONE;
    case (b)
      8'd160, 8'd161, 8'd162, 8'd163: r = 7'h61;
      8'd169, 8'd170:                 r = 7'h65;
      8'd173:                         r = 7'h69;
      8'd179, 8'd180, 8'd181:         r = 7'h6F;
      8'd186:                         r = 7'h75;
      8'd167:                         r = 7'h63;
      default:                        r = CHAR_NONE;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/ufn_fold.sv */
// ----------------------------------------------------------------------------
// ufn_fold
// Classifies one registered byte, folds it, and emits up to two results while
// tracking the lead, started and held-space state of the current string.
// ----------------------------------------------------------------------------
module ufn_fold (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [ufn_pkg::BYTE_W-1:0] byte_in,
  input  logic                     last_in,
  output logic [1:0]               n_res,
  output ufn_pkg::ufn_res_t        res0,
  output ufn_pkg::ufn_res_t        res1
);
  import ufn_pkg::*;

  ufn_state_t        st;
  ufn_state_t        st_next;
  logic [CHAR_W-1:0] ch;
  logic              is_space;
  logic              is_char;
  logic              held_eff;
  logic [BYTE_W-1:0] lower;

  assign lower = byte_in + CASE_OFFSET;

  always_comb begin
    ch = CHAR_NONE;
    if (st.lead_pending) begin
      ch = fold_second(byte_in);
    end else if (byte_in != LEAD_BYTE && byte_in != '0 && !byte_in[BYTE_W-1]) begin
      if (byte_in == BYTE_COMMA || byte_in == BYTE_HYPHEN) begin
        ch = CHAR_SPACE;
      end else if (byte_in >= BYTE_UPPER_A && byte_in <= BYTE_UPPER_Z) begin
        ch = lower[CHAR_W-1:0];
      end else begin
        ch = byte_in[CHAR_W-1:0];
      end
    end
  end

  assign is_space = (ch == CHAR_SPACE);
  assign is_char  = (ch != CHAR_NONE) && !is_space;
  assign held_eff = st.space_held || (is_space && st.text_started);

  always_comb begin
    n_res = 2'd0;
    res0  = '{ch: CHAR_SPACE, valid: 1'b1, last: 1'b0};
    res1  = '{ch: ch, valid: 1'b1, last: last_in};
    if (is_char) begin
      if (st.space_held) begin
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
        res0  = '{ch: ch, valid: 1'b1, last: last_in};
      end
    end else if (last_in) begin
      n_res = 2'd1;
      if (held_eff) begin
        res0 = '{ch: CHAR_SPACE, valid: 1'b1, last: 1'b1};
      end else begin
        res0 = '{ch: CHAR_NONE, valid: 1'b0, last: 1'b1};
      end
    end
  end

  always_comb begin
    st_next = '0;
    if (!last_in) begin
      st_next.lead_pending = !st.lead_pending && (byte_in == LEAD_BYTE);
      st_next.text_started = st.text_started || is_char;
      st_next.space_held   = is_char ? 1'b0 : held_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

endmodule

/* hw/rtl/ufn_outq.sv */
// ----------------------------------------------------------------------------
// ufn_outq
// Two-entry result queue that takes zero, one or two results per cycle while it
// has room for them, and presents the head on the output stream.
// ----------------------------------------------------------------------------
module ufn_outq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               n_push,
  input  ufn_pkg::ufn_res_t        res0,
  input  ufn_pkg::ufn_res_t        res1,
  output logic                     room,
  output logic                     head_valid,
  input  logic                     head_ready,
  output ufn_pkg::ufn_res_t        head
);
  import ufn_pkg::*;

  ufn_res_t         e0;
  ufn_res_t         e1;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W-1:0] cnt_next;
  logic             pop;
  logic             push;

  assign head_valid = (cnt != '0);
  assign head       = e0;
  assign pop        = head_valid && head_ready;
  assign cnt_after  = cnt - CNT_W'(pop);
  assign room       = (CNT_W'(QUEUE_DEPTH) - cnt_after) >= CNT_W'(n_push);
  assign push       = room && (n_push != 2'd0);
  assign cnt_next   = push ? cnt_after + CNT_W'(n_push) : cnt_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && cnt_after == '0) begin
      e0 <= res0;
      e1 <= res1;
    end else begin
      if (pop) begin
        e0 <= e1;
      end
      if (push) begin
        e1 <= res0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue over its depth");

  a_pair_empty: assert property (@(posedge clk) disable iff (rst)
    (push && n_push == 2'd2) |-> cnt_after == '0)
    else $error("result pair pushed into a non-empty queue");

  a_full_drain: assert property (@(posedge clk) disable iff (rst)
    (cnt == CNT_W'(QUEUE_DEPTH) && !head_ready) |=> cnt == CNT_W'(QUEUE_DEPTH))
    else $error("full queue lost an entry while stalled");

endmodule

/* hw/rtl/utf8_accent_fold_normalizer_unit.sv */
// ----------------------------------------------------------------------------
// utf8_accent_fold_normalizer_unit
// Folds UTF-8 accented letters to ASCII, lowercases, maps comma and hyphen to
// space, trims leading spaces and collapses space runs, one byte per beat.
//
//   channel  dir  tdata           tuser      tlast
//   s_*      in   [7:0] in_byte   -          in_last
//   m_*      out  [6:0] out_char  out_valid  out_end
//
// One byte per cycle while the queue has room: input register, fold logic, queue.
// A byte that yields a held space plus a character takes two output beats.
// rst is synchronous, active high; it clears string state, the input register
// and the result queue.
// The input register holds while the result queue lacks room for its results.
// ----------------------------------------------------------------------------
module utf8_accent_fold_normalizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tuser,   // [0] out_valid
  output logic       m_tlast
);
  import ufn_pkg::*;

  logic              in_v;
  logic [BYTE_W-1:0] in_b;
  logic              in_l;
  logic              adv;
  logic              room;
  logic [1:0]        n_res;
  ufn_res_t          res0;
  ufn_res_t          res1;
  ufn_res_t          head;

  assign adv      = in_v && room;
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_b <= s_tdata;
      in_l <= s_tlast;
    end
  end

  ufn_fold u_fold (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .byte_in (in_b),
    .last_in (in_l),
    .n_res   (n_res),
    .res0    (res0),
    .res1    (res1)
  );

  ufn_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .n_push     (in_v ? n_res : 2'd0),
    .res0       (res0),
    .res1       (res1),
    .room       (room),
    .head_valid (m_tvalid),
    .head_ready (m_tready),
    .head       (head)
  );

  assign m_tdata = {1'b0, head.ch};
  assign m_tuser = head.valid;
  assign m_tlast = head.last;

endmodule
